// ----- sv/lz3_pkg.sv -----
// ----------------------------------------------------------------------------
// lz3_pkg
// Shared types and constants for the three-stream LZ decompressor: request
// and result payload structs, stream command codes and error codes.
// ----------------------------------------------------------------------------
package lz3_pkg;

    // History window and derived pointer width
    localparam int WINDOW_SIZE      = 4096;
    localparam int PTR_W            = $clog2(WINDOW_SIZE);
    localparam int DIST_W           = PTR_W + 1;

    // Result packing
    localparam int OUTPUT_LANES_DEF = 8;
    localparam int MAX_LANES        = 8;
    localparam int CNT_W            = 4;

    // Counters and lengths
    localparam int SIZE_W           = 32;
    localparam int PROD_W           = SIZE_W + 1;
    localparam int LEN_W            = 9;
    localparam int BITS_W           = 4;

    // Count word layout and length biases
    localparam int          CODE_LSB       = 12;
    localparam logic [3:0]  CODE_EXTENDED  = 4'd0;
    localparam logic [LEN_W-1:0] SHORT_BIAS = LEN_W'(2);
    localparam logic [LEN_W-1:0] LONG_BIAS  = LEN_W'(18);
    localparam logic [BITS_W-1:0] CTRL_BITS = BITS_W'(8);

    // Stream commands, also used for the expected-next field
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_CTRL  = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_DATA  = 2'd3
    } cmd_t;

    // Latched error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BACKREF  = 2'd1,
        ERR_OVERFLOW = 2'd2,
        ERR_ORDER    = 2'd3
    } err_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        last;
        logic [1:0]  need_next;
        logic        finished;
        logic [1:0]  error;
    } out_item_t;

endpackage

// ----- sv/lz_three_stream_decompressor_top.sv -----
// ----------------------------------------------------------------------------
// lz_three_stream_decompressor_top
// Three-stream LZ decompressor: literal/back-copy decoding over a 4 KiB
// history with results packed several bytes per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_valid/s_ready/s_data: a start request with the
//   frame size, then control bytes, count words and data bytes in the order
//   given by need_next of the previous result. Every request yields one or
//   more results on m_valid/m_ready/m_data; the last one carries last = 1.
//   cfg_wr_en/cfg_wr_data set the output size limit; write it while idle.
//   Timing: s_ready is high only in the idle state. A request that makes no
//   byte or a single literal passes through the decode and flush states, with
//   its result registered, before the block returns to idle for the next
//   accept. A back-copy runs the copy engine between decode and flush: one
//   history read port delivers one byte per cycle while the packer has room,
//   and the packer pauses each time a full beat is handed off before the
//   copy ends.
//   When the receiver stalls, the result register holds and the copy engine
//   waits with a full packer; nothing is dropped.
//   Reset (aresetn low, synchronous) returns to idle, expecting a start
//   request, with the limit cleared. History contents are not cleared; no
//   entry is read before it is written within a frame.
// ----------------------------------------------------------------------------
module lz_three_stream_decompressor_top
    import lz3_pkg::*;
#(
    parameter int OUTPUT_LANES = OUTPUT_LANES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_COPY  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [31:0]           val_reg, val_next;
    logic [31:0]           max_reg;
    logic [SIZE_W-1:0]     target_reg, target_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic [7:0]            shift_reg, shift_next;
    logic [BITS_W-1:0]     bits_reg, bits_next;
    cmd_t                  expect_reg, expect_next;
    logic [DIST_W-1:0]     pend_reg, pend_next;
    err_t                  err_reg, err_next;

    // copy engine
    logic [PTR_W-1:0]      rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0]      reads_left_reg, reads_left_next;
    logic [LEN_W-1:0]      writes_left_reg, writes_left_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  dist1_reg, dist1_next;
    logic                  first_reg, first_next;
    logic [7:0]            last_byte_reg, last_byte_next;
    logic [7:0]            rd_data_reg;

    // packer and result register
    logic [7:0]            pack_reg [OUTPUT_LANES];
    logic [7:0]            pack_next [OUTPUT_LANES];
    logic [CNT_W-1:0]      pack_cnt_reg, pack_cnt_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    // history memory
    logic [7:0]            hist_mem [WINDOW_SIZE];
    logic                  hist_we, hist_re;
    logic [7:0]            wr_byte;

    // ------------------------------------------------------------------
    // Combinational control
    // ------------------------------------------------------------------
    logic                  out_free;
    logic                  consume;
    logic                  issue;
    logic                  emit, emit_last;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign consume  = (state_reg == ST_COPY) && rd_pend_reg &&
                      (pack_cnt_reg < CNT_W'(OUTPUT_LANES));
    assign issue    = (state_reg == ST_COPY) && (reads_left_reg != '0) &&
                      (!rd_pend_reg || consume);
    assign hist_re  = issue;

    always_comb begin
        logic [SIZE_W-1:0] size_clip;
        logic [DIST_W-1:0] word_dist;
        logic [3:0]        code;
        logic              copy_req;
        logic              lit;
        logic              adv;
        logic [DIST_W-1:0] copy_dist;
        logic [LEN_W-1:0]  copy_len;
        logic [PROD_W-1:0] sum;
        logic [PROD_W-1:0] adv_prod;
        logic [BITS_W-1:0] bl;
        logic [63:0]       ob;

        size_clip = '0;
        word_dist = '0;
        code      = '0;
        copy_req  = 1'b0;
        lit       = 1'b0;
        adv       = 1'b0;
        copy_dist = '0;
        copy_len  = '0;
        sum       = '0;
        adv_prod  = '0;
        bl        = '0;
        ob        = '0;

        state_next       = state_reg;
        cmd_next         = cmd_reg;
        val_next         = val_reg;
        target_next      = target_reg;
        prod_next        = prod_reg;
        wp_next          = wp_reg;
        shift_next       = shift_reg;
        bits_next        = bits_reg;
        expect_next      = expect_reg;
        pend_next        = pend_reg;
        err_next         = err_reg;
        rd_addr_next     = rd_addr_reg;
        reads_left_next  = reads_left_reg;
        writes_left_next = writes_left_reg;
        rd_pend_next     = rd_pend_reg;
        dist1_next       = dist1_reg;
        first_next       = first_reg;
        last_byte_next   = last_byte_reg;
        pack_next        = pack_reg;
        pack_cnt_next    = pack_cnt_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        hist_we          = 1'b0;
        wr_byte          = val_reg[7:0];
        emit             = 1'b0;
        emit_last        = 1'b0;

        // retire the current result when the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = cmd_t'(s_data.command);
                    val_next   = s_data.value;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_FLUSH;
                // decode the request against the expected stream
                if (cmd_reg == CMD_START) begin
                    size_clip = ((max_reg != '0) && (val_reg > max_reg)) ? max_reg
                                                                        : val_reg;
                    target_next = size_clip;
                    prod_next   = '0;
                    wp_next     = '0;
                    shift_next  = '0;
                    bits_next   = '0;
                    pend_next   = '0;
                    err_next    = ERR_NONE;
                    expect_next = (size_clip == '0) ? CMD_START : CMD_CTRL;
                end else if (cmd_reg != expect_reg) begin
                    if (err_reg == ERR_NONE) begin
                        err_next = ERR_ORDER;
                    end
                end else begin
                    case (cmd_reg)
                        CMD_CTRL: begin
                            shift_next  = val_reg[7:0];
                            bits_next   = CTRL_BITS;
                            expect_next = val_reg[7] ? CMD_DATA : CMD_COUNT;
                        end
                        CMD_COUNT: begin
                            word_dist = DIST_W'(val_reg[PTR_W-1:0]) + DIST_W'(1);
                            code      = val_reg[CODE_LSB +: 4];
                            if (code == CODE_EXTENDED) begin
                                pend_next   = word_dist;
                                expect_next = CMD_DATA;
                            end else begin
                                copy_req  = 1'b1;
                                copy_dist = word_dist;
                                copy_len  = LEN_W'(code) + SHORT_BIAS;
                            end
                        end
                        CMD_DATA: begin
                            if (pend_reg != '0) begin
                                pend_next = '0;
                                copy_req  = 1'b1;
                                copy_dist = pend_reg;
                                copy_len  = LEN_W'(val_reg[7:0]) + LONG_BIAS;
                            end else begin
                                lit = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // check a back-copy and start the copy engine
                sum = prod_reg + PROD_W'(copy_len);
                if (copy_req) begin
                    if (PROD_W'(copy_dist) > prod_reg) begin
                        if (err_reg == ERR_NONE) begin
                            err_next = ERR_BACKREF;
                        end
                        expect_next = CMD_START;
                    end else if ((max_reg != '0) && (sum > PROD_W'(target_reg)) &&
                                 (max_reg == target_reg)) begin
                        if (err_reg == ERR_NONE) begin
                            err_next = ERR_OVERFLOW;
                        end
                        expect_next = CMD_START;
                    end else begin
                        adv              = 1'b1;
                        adv_prod         = sum;
                        rd_addr_next     = wp_reg - copy_dist[PTR_W-1:0];
                        reads_left_next  = copy_len;
                        writes_left_next = copy_len;
                        rd_pend_next     = 1'b0;
                        dist1_next       = (copy_dist == DIST_W'(1));
                        first_next       = 1'b1;
                        state_next       = ST_COPY;
                    end
                end

                // write one literal byte
                if (lit) begin
                    hist_we  = 1'b1;
                    wr_byte  = val_reg[7:0];
                    wp_next  = wp_reg + PTR_W'(1);
                    adv      = 1'b1;
                    adv_prod = prod_reg + PROD_W'(1);
                end

                // advance the control bit stream to its final position
                if (adv) begin
                    prod_next  = adv_prod;
                    shift_next = {shift_reg[6:0], 1'b0};
                    bl         = (bits_reg == '0) ? '0 : bits_reg - BITS_W'(1);
                    bits_next  = bl;
                    if (adv_prod >= PROD_W'(target_reg)) begin
                        expect_next = CMD_START;
                    end else if (bl == '0) begin
                        expect_next = CMD_CTRL;
                    end else begin
                        expect_next = shift_reg[6] ? CMD_DATA : CMD_COUNT;
                    end
                end
            end

            ST_COPY: begin
                // issue the next history read
                if (issue) begin
                    rd_addr_next    = rd_addr_reg + PTR_W'(1);
                    reads_left_next = reads_left_reg - LEN_W'(1);
                end
                if (issue) begin
                    rd_pend_next = 1'b1;
                end else if (consume) begin
                    rd_pend_next = 1'b0;
                end
                // write the returned byte; repeat the first one at distance one
                if (consume) begin
                    hist_we          = 1'b1;
                    wr_byte          = (dist1_reg && !first_reg) ? last_byte_reg
                                                                 : rd_data_reg;
                    wp_next          = wp_reg + PTR_W'(1);
                    writes_left_next = writes_left_reg - LEN_W'(1);
                    first_next       = 1'b0;
                    last_byte_next   = wr_byte;
                end
                // hand off a full beat mid-copy
                if ((pack_cnt_reg == CNT_W'(OUTPUT_LANES)) &&
                    (writes_left_reg != '0) && out_free) begin
                    emit = 1'b1;
                end
                if (writes_left_reg == '0) begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH: begin
                // send the final result of this request
                if (out_free) begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // pack written bytes into lanes
        if (hist_we) begin
            for (int j = 0; j < OUTPUT_LANES; j++) begin
                if (pack_cnt_reg == CNT_W'(j)) begin
                    pack_next[j] = wr_byte;
                end
            end
            pack_cnt_next = pack_cnt_reg + CNT_W'(1);
        end

        // load the result register and clear the packer
        if (emit) begin
            for (int j = 0; j < OUTPUT_LANES; j++) begin
                ob[8*j +: 8] = pack_reg[j];
            end
            m_data_next.out_bytes  = ob;
            m_data_next.byte_count = pack_cnt_reg;
            m_data_next.last       = emit_last;
            m_data_next.need_next  = expect_reg;
            m_data_next.finished   = (prod_reg >= PROD_W'(target_reg));
            m_data_next.error      = err_reg;
            m_valid_next           = 1'b1;
            for (int j = 0; j < OUTPUT_LANES; j++) begin
                pack_next[j] = '0;
            end
            pack_cnt_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // History memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[wp_reg] <= wr_byte;
        end
        if (hist_re) begin
            rd_data_reg <= hist_mem[rd_addr_reg];
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_reg      <= '0;
            target_reg   <= '0;
            prod_reg     <= '0;
            wp_reg       <= '0;
            shift_reg    <= '0;
            bits_reg     <= '0;
            expect_reg   <= CMD_START;
            pend_reg     <= '0;
            err_reg      <= ERR_NONE;
            reads_left_reg  <= '0;
            writes_left_reg <= '0;
            rd_pend_reg  <= 1'b0;
            pack_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int j = 0; j < OUTPUT_LANES; j++) begin
                pack_reg[j] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
            target_reg   <= target_next;
            prod_reg     <= prod_next;
            wp_reg       <= wp_next;
            shift_reg    <= shift_next;
            bits_reg     <= bits_next;
            expect_reg   <= expect_next;
            pend_reg     <= pend_next;
            err_reg      <= err_next;
            reads_left_reg  <= reads_left_next;
            writes_left_reg <= writes_left_next;
            rd_pend_reg  <= rd_pend_next;
            pack_cnt_reg <= pack_cnt_next;
            m_valid_reg  <= m_valid_next;
            pack_reg     <= pack_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        rd_addr_reg   <= rd_addr_next;
        dist1_reg     <= dist1_next;
        first_reg     <= first_next;
        last_byte_reg <= last_byte_next;
        m_data_reg    <= m_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter decode");

    a_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!rd_pend_reg && (pack_cnt_reg == '0)))
        else $error("idle with pending read or packed bytes");

    a_copy_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |->
            ((reads_left_reg <= writes_left_reg) &&
             (pack_cnt_reg <= CNT_W'(OUTPUT_LANES))))
        else $error("copy engine read ahead of writes or packer overrun");

    a_beat_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> (m_data.byte_count == CNT_W'(OUTPUT_LANES)))
        else $error("non-final result beat not full");

endmodule
